### hdl/spq_pkg.sv
// spq_pkg: shared types and constants of the sorted priority queue
// no dependencies; compiled before every other file of the block

package spq_pkg;

   // fixed field widths of the request and response channels
   localparam int IN_VALUE_WIDTH  = 32;
   localparam int OUT_VALUE_WIDTH = 32;
   localparam int OUT_COUNT_WIDTH = 7;

   // request codes
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // order mode codes
   localparam logic MODE_LARGEST_FIRST  = 1'b0;
   localparam logic MODE_SMALLEST_FIRST = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } spq_status_type;

   // one finished result, from the sequencer to the output register
   typedef struct packed {
      logic signed [OUT_VALUE_WIDTH-1:0] head_value;
      logic signed [OUT_VALUE_WIDTH-1:0] popped_value;
      logic [OUT_COUNT_WIDTH-1:0]        entry_count;
      logic                              is_empty;
      spq_status_type                    status;
   } spq_result_type;

endpackage

### hdl/spq_channels.sv
// spq_channels: valid/ready channel interfaces for requests and responses
// depends on spq_pkg for field widths and the status type

interface spq_req_if
   import spq_pkg::*;
();
   logic                             valid;
   logic                             ready;
   logic                             req_type;
   logic signed [IN_VALUE_WIDTH-1:0] new_value;

   modport source (output valid, output req_type, output new_value, input ready);
   modport sink   (input valid, input req_type, input new_value, output ready);
endinterface

interface spq_rsp_if
   import spq_pkg::*;
();
   logic                              valid;
   logic                              ready;
   logic signed [OUT_VALUE_WIDTH-1:0] head_value;
   logic signed [OUT_VALUE_WIDTH-1:0] popped_value;
   logic [OUT_COUNT_WIDTH-1:0]        entry_count;
   logic                              is_empty;
   spq_status_type                    status;

   modport source (output valid, output head_value, output popped_value,
                   output entry_count, output is_empty, output status, input ready);
   modport sink   (input valid, input head_value, input popped_value,
                   input entry_count, input is_empty, input status, output ready);
endinterface

### hdl/spq_store.sv
// spq_store: entry memory of the queue, one write and one read port
// read data registered; no package dependency

module spq_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/spq_ctrl.sv
// spq_ctrl: request sequencer, ring head pointer and insertion scan over the store
// depends on spq_pkg; drives the ports of spq_store

module spq_ctrl
   import spq_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic signed [IN_VALUE_WIDTH-1:0] new_value,
   input  logic                             order_mode,
   output logic                             res_valid,
   input  logic                             res_ready,
   output spq_result_type                   res,
   output logic                             queue_empty,
   output logic                             mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]      mem_wr_addr,
   output logic [VALUE_WIDTH-1:0]           mem_wr_data,
   output logic [$clog2(CAPACITY)-1:0]      mem_rd_addr,
   input  logic [VALUE_WIDTH-1:0]           mem_rd_data
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [ADDR_W:0]  DEPTH_X   = (ADDR_W + 1)'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   typedef enum logic [2:0] {
      IDLE,
      SCAN_RD,
      SCAN,
      PUT0,
      POP_RD,
      POP_WAIT,
      DONE
   } state_type;

   state_type                state_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [ADDR_W-1:0]        head_ptr_ff;
   logic [ADDR_W-1:0]        k_ff;
   logic signed [VALUE_WIDTH-1:0] head_ff;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] popped_ff;
   spq_status_type           status_ff;

   logic signed [VALUE_WIDTH-1:0] entry;
   logic                     entry_first;
   logic                     accept;

   // logical position to ring address
   function automatic logic [ADDR_W-1:0] to_phys(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] ofs);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, ofs};
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[ADDR_W-1:0];
   endfunction

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == IDLE);
   assign queue_empty = (count_ff == '0);
   assign entry       = mem_rd_data;

   // stored entry goes strictly ahead of the new value
   assign entry_first = (order_mode == MODE_SMALLEST_FIRST) ? (entry < value_ff)
                                                            : (entry > value_ff);

   // store port control
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = to_phys(head_ptr_ff, k_ff + ADDR_W'(1));
      mem_wr_data = entry;
      mem_rd_addr = to_phys(head_ptr_ff, k_ff);
      unique case (state_ff)
         SCAN: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = entry_first ? value_ff : entry;
            mem_rd_addr = to_phys(head_ptr_ff, k_ff - ADDR_W'(1));
         end
         PUT0: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = head_ptr_ff;
            mem_wr_data = value_ff;
         end
         POP_RD: begin
            mem_rd_addr = head_ptr_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      res_valid          = (state_ff == DONE) && res_ready;
      res.head_value     = queue_empty ? '0 : OUT_VALUE_WIDTH'(head_ff);
      res.popped_value   = OUT_VALUE_WIDTH'(popped_ff);
      res.entry_count    = OUT_COUNT_WIDTH'(count_ff);
      res.is_empty       = queue_empty;
      res.status         = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         count_ff    <= '0;
         head_ptr_ff <= '0;
         status_ff   <= STATUS_OK;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  value_ff  <= VALUE_WIDTH'(new_value);
                  popped_ff <= '0;
                  status_ff <= STATUS_OK;
                  if (req_type == REQ_PUSH) begin
                     if (count_ff == CAP_COUNT) begin
                        status_ff <= STATUS_FULL;
                        state_ff  <= DONE;
                     end else if (count_ff == '0) begin
                        state_ff <= PUT0;
                     end else begin
                        k_ff     <= ADDR_W'(count_ff - CNT_W'(1));
                        state_ff <= SCAN_RD;
                     end
                  end else begin
                     if (count_ff == '0) begin
                        status_ff <= STATUS_EMPTY;
                        state_ff  <= DONE;
                     end else begin
                        popped_ff   <= head_ff;
                        head_ptr_ff <= to_phys(head_ptr_ff, ADDR_W'(1));
                        count_ff    <= count_ff - CNT_W'(1);
                        state_ff    <= (count_ff == CNT_W'(1)) ? DONE : POP_RD;
                     end
                  end
               end
            end
            SCAN_RD: begin
               state_ff <= SCAN;
            end
            SCAN: begin
               // entry at k moves to k+1 unless the new value lands there
               if (entry_first) begin
                  count_ff <= count_ff + CNT_W'(1);
                  state_ff <= DONE;
               end else if (k_ff == '0) begin
                  state_ff <= PUT0;
               end else begin
                  k_ff <= k_ff - ADDR_W'(1);
               end
            end
            PUT0: begin
               head_ff  <= value_ff;
               count_ff <= count_ff + CNT_W'(1);
               state_ff <= DONE;
            end
            POP_RD: begin
               state_ff <= POP_WAIT;
            end
            POP_WAIT: begin
               head_ff  <= entry;
               state_ff <= DONE;
            end
            DONE: begin
               if (res_ready) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

### hdl/sorted_priority_queue_unit.sv
// sorted_priority_queue_unit: top level of the sorted priority queue
// depends on spq_pkg, spq_channels (interfaces), spq_store and spq_ctrl
//
// channel   ports           dir  transfer when           payload
// -------   -------------   ---  ----------------------  ------------------------------------
// request   req_bus.*       in   valid && ready          req_type, new_value
// response  rsp_bus.*       out  valid && ready          head_value, popped_value,
//                                                        entry_count, is_empty, status
// config    csr_write_*     in   csr_write_enable high   order_mode (csr_write_data)
//
// one request at a time; each yields exactly one response transfer
// push into an empty queue: the value is written straight to the head (PUT0);
//   otherwise a read-compare-write scan (SCAN_RD, SCAN) moves each entry that
//   goes behind the new value one place down, up to the whole occupancy, through
//   the single read and single write port of the entry store; full queue: rejected
// pop: goes straight to the response when it empties the queue or is rejected,
//   otherwise one store read fetches the new head (POP_RD, POP_WAIT)
// entries live in a ring: a pop advances the head pointer and moves no entries
// reset clears occupancy, the head pointer and order mode; the store needs no clearing
// a waiting response does not block the next request transfer; a new
//   response only waits if the output register is still occupied
// order mode writes are ignored while the queue holds entries

module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_bus,
   spq_rsp_if.source  rsp_bus,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   localparam int ADDR_W = $clog2(CAPACITY);

   // order mode register
   logic order_mode_ff;

   // response output register
   logic           rsp_valid_ff;
   spq_result_type rsp_data_ff;

   // sequencer to output register
   logic           res_valid;
   logic           res_ready;
   spq_result_type res;
   logic           queue_empty;

   // store ports
   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic [VALUE_WIDTH-1:0] mem_wr_data;
   logic [ADDR_W-1:0]      mem_rd_addr;
   logic [VALUE_WIDTH-1:0] mem_rd_data;

   // mode only changes on an empty queue so stored order stays valid
   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff <= MODE_LARGEST_FIRST;
      end else if (csr_write_enable && queue_empty) begin
         order_mode_ff <= csr_write_data;
      end
   end

   // output register takes a result when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.head_value   = rsp_data_ff.head_value;
   assign rsp_bus.popped_value = rsp_data_ff.popped_value;
   assign rsp_bus.entry_count  = rsp_data_ff.entry_count;
   assign rsp_bus.is_empty     = rsp_data_ff.is_empty;
   assign rsp_bus.status       = rsp_data_ff.status;

   spq_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_type    (req_bus.req_type),
      .new_value   (req_bus.new_value),
      .order_mode  (order_mode_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .queue_empty (queue_empty),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   spq_store #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // a result is only issued when the output register can take it
   a_no_result_lost: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> res_ready)
      else $error("result issued while output register full");

   // order mode never moves while entries are held
   a_mode_frozen: assert property (@(posedge clock) disable iff (reset)
      !queue_empty |=> $stable(order_mode_ff))
      else $error("order mode changed on a non-empty queue");

   // an empty queue reports a zero head
   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.is_empty) |-> (res.head_value == '0))
      else $error("empty queue reported a non-zero head");

   // rejected requests leave no popped value
   a_reject_no_pop: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.status == STATUS_FULL || res.status == STATUS_EMPTY))
         |-> (res.popped_value == '0))
      else $error("rejected request reported a popped value");

endmodule

### sim/tb_top.sv
// tb_top: self-checking testbench of sorted_priority_queue_unit, push/pop and order mode
// depends on spq_pkg, spq_channels and the top level of the block

module tb_top
   import spq_pkg::*;
();

   localparam int QUEUE_DEPTH = 64;

   // ------------------------------------------------------------------
   // expected-result tracker: keeps its own sorted copy of the queue,
   // works out each response at request transfer time and holds it
   // until the matching response transfer shows up
   // ------------------------------------------------------------------
   class spq_scoreboard;
      logic signed [OUT_VALUE_WIDTH-1:0] held_values[$];
      logic                              order_mode;
      spq_result_type                    awaited_results[$];
      int unsigned                       mismatches;
      int                                depth;

      function new(int depth);
         this.depth = depth;
         order_mode = MODE_LARGEST_FIRST;
         mismatches = 0;
      endfunction

      // a mode write only lands while the queue is empty
      function void write_order(logic mode);
         if (held_values.size() == 0)
            order_mode = mode;
      endfunction

      // true when a held entry is served strictly ahead of value
      function bit served_first(logic signed [OUT_VALUE_WIDTH-1:0] held,
                                logic signed [OUT_VALUE_WIDTH-1:0] value);
         if (order_mode == MODE_SMALLEST_FIRST)
            return held < value;
         return held > value;
      endfunction

      function void note_request(logic kind, logic signed [OUT_VALUE_WIDTH-1:0] value);
         spq_result_type want;
         int unsigned    pos;
         want.popped_value = '0;
         want.status = STATUS_OK;
         if (kind == REQ_PUSH) begin
            if (held_values.size() >= depth) begin
               want.status = STATUS_FULL;
            end else begin
               // equal values go ahead of the ones already held
               pos = 0;
               while (pos < held_values.size() && served_first(held_values[pos], value))
                  pos++;
               held_values.insert(pos, value);
            end
         end else if (held_values.size() == 0) begin
            want.status = STATUS_EMPTY;
         end else begin
            want.popped_value = held_values.pop_front();
         end
         want.entry_count = OUT_COUNT_WIDTH'(held_values.size());
         want.is_empty = (held_values.size() == 0);
         want.head_value = want.is_empty ? '0 : held_values[0];
         awaited_results.push_back(want);
      endfunction

      function void log_mismatch(string field, logic signed [31:0] want,
                                 logic signed [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      endfunction

      function void check_response(spq_result_type got);
         spq_result_type want;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response with nothing awaited: head %0d count %0d",
                        got.head_value, got.entry_count);
            return;
         end
         want = awaited_results.pop_front();
         if (got.head_value !== want.head_value)
            log_mismatch("head_value", want.head_value, got.head_value);
         if (got.popped_value !== want.popped_value)
            log_mismatch("popped_value", want.popped_value, got.popped_value);
         if (got.entry_count !== want.entry_count)
            log_mismatch("entry_count", want.entry_count, got.entry_count);
         if (got.is_empty !== want.is_empty)
            log_mismatch("is_empty", want.is_empty, got.is_empty);
         if (got.status !== want.status)
            log_mismatch("status", want.status, got.status);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic csr_write_data;
   bit   idling_on = 1'b1;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   spq_scoreboard sb = new(QUEUE_DEPTH);

   sorted_priority_queue_unit #(
      .CAPACITY    (QUEUE_DEPTH),
      .VALUE_WIDTH (IN_VALUE_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // gap length for either side: mostly none or short, now and then long
   function automatic int unsigned stall_cycles();
      int unsigned roll;
      if (!idling_on)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // push operand: wide random, clustered near zero for ties, moderate, or an extreme
   function automatic logic signed [IN_VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom;
         5, 6, 7: return $signed($urandom_range(0, 8)) - 4;
         8: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh0;
               default: return -32'sd1;
            endcase
         end
         default: return $signed($urandom_range(0, 1000)) - 500;
      endcase
   endfunction

   // transfer monitor: both channels sampled at the rising edge, before
   // any update of this edge lands, so the check is order independent
   always @(posedge clock) begin
      spq_result_type got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.head_value   = rsp_bus.head_value;
            got.popped_value = rsp_bus.popped_value;
            got.entry_count  = rsp_bus.entry_count;
            got.is_empty     = rsp_bus.is_empty;
            got.status       = rsp_bus.status;
            sb.check_response(got);
         end
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.req_type, req_bus.new_value);
      end
   end

   // response side back-pressure: stall bursts between ready runs
   initial begin
      int unsigned hold;
      rsp_bus.ready = 1'b0;
      forever begin
         hold = stall_cycles();
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // one request transfer, after an optional gap; returns on the accepting
   // edge with valid still high so back-to-back requests stay seamless
   task automatic send_request(logic kind, logic signed [IN_VALUE_WIDTH-1:0] value);
      int unsigned gap;
      gap = stall_cycles();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.new_value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // drop valid and wait for every awaited response, plus a short margin
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // order mode write, only ever issued while no request is in flight
   task automatic write_order(logic mode);
      settle();
      csr_write_data   <= mode;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      sb.write_order(mode);
      csr_write_enable <= 1'b0;
   endtask

   // pop everything that is held, then one more pop on the empty queue
   task automatic drain_queue();
      settle();
      repeat (sb.held_values.size() + 1) send_request(REQ_POP, $urandom);
   endtask

   initial begin
      int   push_share[4];
      logic phase_mode;
      logic kind;

      push_share        = '{50, 85, 30, 65};
      req_bus.valid     = 1'b0;
      req_bus.req_type  = REQ_PUSH;
      req_bus.new_value = '0;
      csr_write_enable  = 1'b0;
      csr_write_data    = MODE_LARGEST_FIRST;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, largest first out of reset: pop on empty, extremes, ties
      send_request(REQ_POP, 32'sh1234_5678);
      send_request(REQ_PUSH, 32'sd5);
      send_request(REQ_PUSH, -32'sd3);
      send_request(REQ_PUSH, 32'sh7FFF_FFFF);
      send_request(REQ_PUSH, 32'sh8000_0000);
      send_request(REQ_PUSH, 32'sh0);
      send_request(REQ_PUSH, -32'sd1);
      send_request(REQ_PUSH, 32'sd5);
      send_request(REQ_POP, 32'sh0);
      send_request(REQ_POP, -32'sd1);
      drain_queue();

      // smallest first, then a mode write that must bounce off a busy queue
      write_order(MODE_SMALLEST_FIRST);
      send_request(REQ_PUSH, 32'sd3);
      send_request(REQ_PUSH, 32'sh8000_0000);
      send_request(REQ_PUSH, 32'sh7FFF_FFFF);
      send_request(REQ_PUSH, 32'sd3);
      write_order(MODE_LARGEST_FIRST);
      drain_queue();

      // random phases: push share varies so the queue both fills up and
      // runs dry; two phases run without any idling on either side
      for (int p = 0; p < 8; p++) begin
         idling_on = (p != 2 && p != 5);
         phase_mode = p[0] ? MODE_SMALLEST_FIRST : MODE_LARGEST_FIRST;
         write_order(phase_mode);
         for (int n = 0; n < 125; n++) begin
            // mid-phase mode flip, lands only if the queue happens to be empty
            if (n == 62)
               write_order(~phase_mode);
            kind = ($urandom_range(0, 99) < push_share[p % 4]) ? REQ_PUSH : REQ_POP;
            send_request(kind, (kind == REQ_PUSH) ? pick_value() : $urandom);
         end
         drain_queue();
      end

      idling_on = 1'b1;
      settle();
      repeat (80) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog
   initial begin
      #15_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
